>>> rtl/json_byte_tokenizer_assert.svh
// Assertion macros used by the checker of the JSON byte tokenizer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef JSON_BYTE_TOKENIZER_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_ASSERT_SVH

// General property, checked on every clock edge outside reset.
`define JBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A stalled result must keep the given signal unchanged.
`define JBT_ASSERT_HOLD(label, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) vld && !rdy |=> $stable(sig)) \
    else $error(msg);

`endif

>>> rtl/jbt_pkg.sv
// Package of the JSON byte tokenizer: mode, token and error codes, result types
// and the small character classification functions. No dependencies.
package jbt_pkg;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0,
    M_STR  = 4'd1,
    M_ESC  = 4'd2,
    M_INT  = 4'd3,
    M_FRAC = 4'd4,
    M_EXPS = 4'd5,
    M_EXPD = 4'd6,
    M_KW   = 4'd7,
    M_ERR  = 4'd8,
    M_DONE = 4'd9
  } mode_t;

  typedef enum logic [3:0] {
    K_OBJ_START = 4'd0,
    K_OBJ_END   = 4'd1,
    K_ARR_START = 4'd2,
    K_ARR_END   = 4'd3,
    K_COMMA     = 4'd4,
    K_COLON     = 4'd5,
    K_STR_START = 4'd6,
    K_STR_BYTE  = 4'd7,
    K_STR_END   = 4'd8,
    K_NUM_BYTE  = 4'd9,
    K_NUM_END   = 4'd10,
    K_TRUE      = 4'd11,
    K_FALSE     = 4'd12,
    K_NULL      = 4'd13,
    K_END       = 4'd14,
    K_ERROR     = 4'd15
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE       = 3'd0,
    E_UNEXPECTED = 3'd1,
    E_BAD_ESC    = 3'd2,
    E_UNTERM     = 3'd3,
    E_BAD_KW     = 3'd4
  } err_t;

  localparam int MaxRes = 3;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus = 8'h2b;
  localparam logic [7:0] ChDot = 8'h2e;
  localparam logic [7:0] ChLowE = 8'h65;
  localparam logic [7:0] ChUpE = 8'h45;
  localparam logic [7:0] ChZero = 8'h00;

  typedef logic [1:0] cnt_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    err_t       err;
  } tok_t;

  typedef struct packed {
    tok_t [MaxRes-1:0] tok;
    cnt_t              cnt;
  } group_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_in;
    logic       end_of_doc;
  } stage_t;

  typedef struct packed {
    logic [2:0] cand;
    logic [2:0] len;
  } kw_t;

  typedef struct packed {
    logic  emit;
    tok_t  tok;
    mode_t mode;
    logic  kw;
  } start_t;

  typedef struct packed {
    logic  ok;
    kind_t kind;
  } kw_close_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] d;
  } esc_t;

  function automatic tok_t mk_tok(kind_t kind, logic [7:0] value, err_t err);
    tok_t t;
    t.kind = kind;
    t.value = value;
    t.err = err;
    return t;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return c inside {[8'h09:8'h0d], 8'h20};
  endfunction

  // Letters of true, false and null; zero past the end of each word.
  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: begin
        case (idx)
          3'd0: r = 8'h74;
          3'd1: r = 8'h72;
          3'd2: r = 8'h75;
          3'd3: r = 8'h65;
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0: r = 8'h66;
          3'd1: r = 8'h61;
          3'd2: r = 8'h6c;
          3'd3: r = 8'h73;
          3'd4: r = 8'h65;
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0: r = 8'h6e;
          3'd1: r = 8'h75;
          3'd2: r = 8'h6c;
          3'd3: r = 8'h6c;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] k);
    logic [2:0] r;
    case (k)
      2'd0: r = 3'd4;
      2'd1: r = 3'd5;
      2'd2: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Drops the keywords that the next letter rules out; length saturates at 7.
  function automatic kw_t kw_add(logic [2:0] cand, logic [2:0] len, logic [7:0] c);
    kw_t r;
    r.cand = cand;
    for (int k = 0; k < 3; k++) begin
      if (len >= kw_len(2'(k)) || kw_char(2'(k), len) != c) begin
        r.cand[k] = 1'b0;
      end
    end
    r.len = (len < 3'd7) ? len + 3'd1 : len;
    return r;
  endfunction

  function automatic kw_close_t kw_close(logic [2:0] cand, logic [2:0] len);
    kw_close_t r;
    r.ok = 1'b0;
    r.kind = K_TRUE;
    for (int k = 2; k >= 0; k--) begin
      if (cand[k] && len == kw_len(2'(k))) begin
        r.ok = 1'b1;
        r.kind = kind_t'(4'(K_TRUE) + 4'(k));
      end
    end
    return r;
  endfunction

  function automatic esc_t esc_decode(logic [7:0] c);
    esc_t r;
    r.ok = 1'b1;
    case (c)
      ChQuote, ChBslash, ChSlash: r.d = c;
      8'h62: r.d = 8'h08;
      8'h66: r.d = 8'h0c;
      8'h6e: r.d = 8'h0a;
      8'h72: r.d = 8'h0d;
      8'h74: r.d = 8'h09;
      default: begin
        r.ok = 1'b0;
        r.d = 8'h00;
      end
    endcase
    return r;
  endfunction

  // Effect of a byte seen between tokens: at most one result and a new mode.
  function automatic start_t start_tok(logic [7:0] c);
    start_t r;
    r.emit = 1'b1;
    r.tok = mk_tok(K_OBJ_START, 8'h00, E_NONE);
    r.mode = M_IDLE;
    r.kw = 1'b0;
    case (c)
      8'h7b: r.tok.kind = K_OBJ_START;
      8'h7d: r.tok.kind = K_OBJ_END;
      8'h5b: r.tok.kind = K_ARR_START;
      8'h5d: r.tok.kind = K_ARR_END;
      8'h2c: r.tok.kind = K_COMMA;
      8'h3a: r.tok.kind = K_COLON;
      ChQuote: begin
        r.tok.kind = K_STR_START;
        r.mode = M_STR;
      end
      default: begin
        if (is_ws(c)) begin
          r.emit = 1'b0;
        end else if (is_digit(c) || c == ChMinus) begin
          r.tok = mk_tok(K_NUM_BYTE, c, E_NONE);
          r.mode = M_INT;
        end else if (is_letter(c)) begin
          r.emit = 1'b0;
          r.mode = M_KW;
          r.kw = 1'b1;
        end else begin
          r.tok = mk_tok(K_ERROR, 8'h00, E_UNEXPECTED);
          r.mode = M_ERR;
        end
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/jbt_ifs.sv
// Handshake channels of the JSON byte tokenizer: document bytes in, tokens out.
// Valid/ready, an item moves when both are high. No dependencies.
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_doc;
  modport source(output valid, char_in, end_of_doc, input ready);
  modport sink(input valid, char_in, end_of_doc, output ready);
endinterface

interface jbt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] value;
  logic [2:0] error_code;
  logic       last_in_run;
  modport source(output valid, kind, value, error_code, last_in_run, input ready);
  modport sink(input valid, kind, value, error_code, last_in_run, output ready);
endinterface

>>> rtl/jbt_in_reg.sv
// Input register of the JSON byte tokenizer: holds one document byte for the lexer.
// Uses jbt_pkg and the jbt_in_if channel.
module jbt_in_reg (
  input  logic            clk,
  input  logic            rst,
  jbt_in_if.sink          din,
  input  logic            take,
  output jbt_pkg::stage_t stage
);

  jbt_pkg::stage_t held;

  assign din.ready = !held.valid || take;
  assign stage = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      held.valid <= 1'b1;
    end else if (take) begin
      held.valid <= 1'b0;
    end
    if (din.valid && din.ready) begin
      held.char_in <= din.char_in;
      held.end_of_doc <= din.end_of_doc;
    end
  end

endmodule

>>> rtl/jbt_lex.sv
// Lexer step of the JSON byte tokenizer: lexer state registers and the per-byte
// decode into a group of up to three tokens. Uses jbt_pkg.
module jbt_lex (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      c,
  input  logic            last,
  output jbt_pkg::group_t grp
);

  jbt_pkg::mode_t mode, mode_next;
  logic [2:0] cand, cand_next;
  logic [2:0] len, len_next;

  jbt_pkg::group_t   g;
  jbt_pkg::start_t   st;
  jbt_pkg::kw_t      kw;
  jbt_pkg::kw_close_t kc;
  jbt_pkg::kw_close_t kf;
  jbt_pkg::esc_t     esc;
  logic              do_start;

  function automatic logic is_num_digit(logic [7:0] ch);
    return jbt_pkg::is_digit(ch);
  endfunction

  always_comb begin
    g = '0;
    mode_next = mode;
    cand_next = cand;
    len_next = len;
    do_start = 1'b0;
    st = jbt_pkg::start_tok(c);
    esc = jbt_pkg::esc_decode(c);
    kw = jbt_pkg::kw_add(cand, len, c);
    kc = jbt_pkg::kw_close(cand, len);
    kf = kc;
    if (mode != jbt_pkg::M_ERR && mode != jbt_pkg::M_DONE) begin
      if (c != jbt_pkg::ChZero) begin
        case (mode)
          jbt_pkg::M_STR: begin
            if (c == jbt_pkg::ChQuote) begin
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_STR_END, 8'h00, jbt_pkg::E_NONE);
              g.cnt = g.cnt + 2'd1;
              mode_next = jbt_pkg::M_IDLE;
            end else if (c == jbt_pkg::ChBslash) begin
              mode_next = jbt_pkg::M_ESC;
            end else begin
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_STR_BYTE, c, jbt_pkg::E_NONE);
              g.cnt = g.cnt + 2'd1;
            end
          end
          jbt_pkg::M_ESC: begin
            if (esc.ok) begin
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_STR_BYTE, esc.d, jbt_pkg::E_NONE);
              mode_next = jbt_pkg::M_STR;
            end else begin
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_ERROR, 8'h00, jbt_pkg::E_BAD_ESC);
              mode_next = jbt_pkg::M_ERR;
            end
            g.cnt = g.cnt + 2'd1;
          end
          jbt_pkg::M_INT, jbt_pkg::M_FRAC, jbt_pkg::M_EXPS, jbt_pkg::M_EXPD: begin
            if ((mode != jbt_pkg::M_EXPS && is_num_digit(c)) ||
                (mode == jbt_pkg::M_EXPS &&
                 (is_num_digit(c) || c == jbt_pkg::ChPlus || c == jbt_pkg::ChMinus))) begin
              if (mode == jbt_pkg::M_EXPS) begin
                mode_next = jbt_pkg::M_EXPD;
              end
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_NUM_BYTE, c, jbt_pkg::E_NONE);
              g.cnt = g.cnt + 2'd1;
            end else if (mode == jbt_pkg::M_INT && c == jbt_pkg::ChDot) begin
              mode_next = jbt_pkg::M_FRAC;
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_NUM_BYTE, c, jbt_pkg::E_NONE);
              g.cnt = g.cnt + 2'd1;
            end else if ((mode == jbt_pkg::M_INT || mode == jbt_pkg::M_FRAC) &&
                         (c == jbt_pkg::ChLowE || c == jbt_pkg::ChUpE)) begin
              mode_next = jbt_pkg::M_EXPS;
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_NUM_BYTE, c, jbt_pkg::E_NONE);
              g.cnt = g.cnt + 2'd1;
            end else begin
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_NUM_END, 8'h00, jbt_pkg::E_NONE);
              g.cnt = g.cnt + 2'd1;
              do_start = 1'b1;
            end
          end
          jbt_pkg::M_KW: begin
            if (jbt_pkg::is_letter(c)) begin
              cand_next = kw.cand;
              len_next = kw.len;
            end else if (kc.ok) begin
              g.tok[g.cnt] = jbt_pkg::mk_tok(kc.kind, 8'h00, jbt_pkg::E_NONE);
              g.cnt = g.cnt + 2'd1;
              mode_next = jbt_pkg::M_IDLE;
              do_start = 1'b1;
            end else begin
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_ERROR, 8'h00, jbt_pkg::E_BAD_KW);
              g.cnt = g.cnt + 2'd1;
              mode_next = jbt_pkg::M_ERR;
            end
          end
          default: begin
            do_start = 1'b1;
          end
        endcase
        if (do_start) begin
          mode_next = st.mode;
          if (st.emit) begin
            g.tok[g.cnt] = st.tok;
            g.cnt = g.cnt + 2'd1;
          end
          if (st.kw) begin
            kw = jbt_pkg::kw_add(3'b111, 3'd0, c);
            cand_next = kw.cand;
            len_next = kw.len;
          end
        end
      end
      // End of document: close whatever is open, then the end token.
      if ((c == jbt_pkg::ChZero || last) && mode_next != jbt_pkg::M_ERR) begin
        kf = jbt_pkg::kw_close(cand_next, len_next);
        case (mode_next)
          jbt_pkg::M_STR: begin
            g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_ERROR, 8'h00, jbt_pkg::E_UNTERM);
            g.cnt = g.cnt + 2'd1;
            mode_next = jbt_pkg::M_ERR;
          end
          jbt_pkg::M_ESC: begin
            g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_ERROR, 8'h00, jbt_pkg::E_BAD_ESC);
            g.cnt = g.cnt + 2'd1;
            mode_next = jbt_pkg::M_ERR;
          end
          jbt_pkg::M_INT, jbt_pkg::M_FRAC, jbt_pkg::M_EXPS, jbt_pkg::M_EXPD: begin
            // With two results already out, the end token closes the number too.
            if (g.cnt < 2'd2) begin
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_NUM_END, 8'h00, jbt_pkg::E_NONE);
              g.cnt = g.cnt + 2'd1;
            end
            g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_END, 8'h00, jbt_pkg::E_NONE);
            g.cnt = g.cnt + 2'd1;
            mode_next = jbt_pkg::M_DONE;
          end
          jbt_pkg::M_KW: begin
            if (kf.ok) begin
              g.tok[g.cnt] = jbt_pkg::mk_tok(kf.kind, 8'h00, jbt_pkg::E_NONE);
              g.tok[g.cnt + 2'd1] = jbt_pkg::mk_tok(jbt_pkg::K_END, 8'h00, jbt_pkg::E_NONE);
              g.cnt = g.cnt + 2'd2;
              mode_next = jbt_pkg::M_DONE;
            end else begin
              g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_ERROR, 8'h00, jbt_pkg::E_BAD_KW);
              g.cnt = g.cnt + 2'd1;
              mode_next = jbt_pkg::M_ERR;
            end
          end
          default: begin
            g.tok[g.cnt] = jbt_pkg::mk_tok(jbt_pkg::K_END, 8'h00, jbt_pkg::E_NONE);
            g.cnt = g.cnt + 2'd1;
            mode_next = jbt_pkg::M_DONE;
          end
        endcase
      end
    end
    if (last) begin
      mode_next = jbt_pkg::M_IDLE;
      cand_next = 3'd0;
      len_next = 3'd0;
    end
  end

  assign grp = g;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jbt_pkg::M_IDLE;
      cand <= 3'd0;
      len <= 3'd0;
    end else if (step) begin
      mode <= mode_next;
      cand <= cand_next;
      len <= len_next;
    end
  end

endmodule

>>> rtl/jbt_res_buf.sv
// Result register of the JSON byte tokenizer: holds the tokens of one byte and
// hands them out one per cycle while dout is ready. Uses jbt_pkg, jbt_out_if.
module jbt_res_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  jbt_pkg::group_t grp,
  output logic            free,
  jbt_out_if.source       dout
);

  jbt_pkg::group_t held;
  jbt_pkg::cnt_t   rem;
  jbt_pkg::cnt_t   pos;
  jbt_pkg::tok_t   cur;

  assign cur = held.tok[pos];
  assign free = (rem == 2'd0) || (rem == 2'd1 && dout.ready);

  assign dout.valid = (rem != 2'd0);
  assign dout.kind = cur.kind;
  assign dout.value = cur.value;
  assign dout.error_code = cur.err;
  assign dout.last_in_run = (rem == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      pos <= 2'd0;
    end else if (load) begin
      rem <= grp.cnt;
      pos <= 2'd0;
    end else if (dout.valid && dout.ready) begin
      rem <= rem - 2'd1;
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= grp;
    end
  end

endmodule

>>> rtl/json_byte_tokenizer.sv
// Streaming JSON lexer: one document byte in, zero to three tokens out.
// Uses jbt_pkg, jbt_ifs, jbt_in_reg, jbt_lex and jbt_res_buf.
//
// The block takes one document byte per item on din and sends tokens on dout,
// one token per item, with last_in_run set on the final token a byte caused.
// A byte passes an input register, is decoded combinationally against the lexer
// state, and its tokens land together in a result register; the first token is
// offered on dout once the byte has passed both registers, and a stall at the
// result register can come between them. A new byte is accepted every cycle
// as long as each byte yields at most one token and dout is ready; a byte that
// yields several tokens occupies the single token port until all are taken,
// and the next byte waits for that one result port.
// Whitespace and letters inside a keyword yield no token.
// After an error, or after a zero byte, the block stays silent until a byte
// flagged end_of_doc arrives, which also returns it to its reset state.
module json_byte_tokenizer (
  input logic       clk,
  input logic       rst,
  jbt_in_if.sink    din,
  jbt_out_if.source dout
);

  jbt_pkg::stage_t stage;
  jbt_pkg::group_t grp;
  logic            free;
  logic            step;

  // A staged byte moves on once the result register has room for its tokens.
  assign step = stage.valid && free;

  jbt_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .din   (din),
    .take  (free),
    .stage (stage)
  );

  jbt_lex u_lex (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .c    (stage.char_in),
    .last (stage.end_of_doc),
    .grp  (grp)
  );

  jbt_res_buf u_res_buf (
    .clk  (clk),
    .rst  (rst),
    .load (step),
    .grp  (grp),
    .free (free),
    .dout (dout)
  );

endmodule

>>> rtl/jbt_checker.sv
// Port checker of the JSON byte tokenizer, bound to the top level.
// Uses jbt_pkg and the macros of json_byte_tokenizer_assert.svh.
`include "json_byte_tokenizer_assert.svh"

module jbt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] kind,
  input logic [7:0] value,
  input logic [2:0] error_code,
  input logic       last_in_run
);

  `JBT_ASSERT_HOLD(a_stall_hold, out_valid, out_ready, {kind, value, error_code, last_in_run}, "stalled item changed")
  `JBT_ASSERT(a_err_code, out_valid |-> ((kind == jbt_pkg::K_ERROR) == (error_code != jbt_pkg::E_NONE)), "error code does not match kind")
  `JBT_ASSERT(a_value_zero, out_valid && kind != jbt_pkg::K_STR_BYTE && kind != jbt_pkg::K_NUM_BYTE |-> value == 8'h00, "value set on a token without payload")
  `JBT_ASSERT(a_final_tok, out_valid && (kind == jbt_pkg::K_END || kind == jbt_pkg::K_ERROR) |-> last_in_run, "end or error token is not the last of its byte")

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .kind        (dout.kind),
  .value       (dout.value),
  .error_code  (dout.error_code),
  .last_in_run (dout.last_in_run)
);
